>>> sv/abfs_pkg.sv
package abfs_pkg;

    localparam int MAX_BITS   = 1024;
    localparam int WORD_W     = 64;
    localparam int RAM_DEPTH  = MAX_BITS / WORD_W;
    localparam int WADDR_W    = $clog2(RAM_DEPTH);
    localparam int OFF_W      = $clog2(WORD_W);
    localparam int POS_W      = 10;
    localparam int CNT_W      = 11;
    localparam int BYTE_W     = 8;
    localparam int BYTE_SEL_W = $clog2(WORD_W / BYTE_W);
    localparam int BIT_SEL_W  = $clog2(BYTE_W);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FIND  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [POS_W-1:0] position;
        logic             bit_value;
    } req_t;

    typedef struct packed {
        status_t           status_code;
        logic [POS_W-1:0]  found_position;
        logic              read_bit;
        logic [BYTE_W-1:0] entry_byte;
    } rsp_t;

endpackage

>>> sv/abfs_ram.sv
module abfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/allocation_bitmap_find_set_unit.sv
// allocation bitmap with first-match search. the bitmap (1024 bits) lives in a
// 16 x 64-bit synchronous ram; a valid bit per ram word, cleared at reset, makes
// an unwritten word read as all zeros, so there is no clearing pass after reset.
// each request transaction carries an opcode: read one bit, write one bit (the
// updated byte holding it is returned), or find the first position at or after
// the start whose bit equals bit_value. for read, write and find, positions at or
// beyond bits_in_use (saturated to 1024) answer out of range; the unused opcode
// always answers ok. one request is worked on at a time.
// read and write go from acceptance through the access and response states to
// the response register; a find scans one 64-bit word per cycle, set by the one
// ram read port streaming a word per cycle, then enters the response state.
// the response register lets the next request be accepted while a result
// still waits on rsp_stall. bits_in_use is written through cfg_write/cfg_data.
module allocation_bitmap_find_set_unit
    import abfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp_data,
    input  logic             cfg_write,
    input  logic [CNT_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_FIND,
        S_RESP
    } state_t;

    // lowest set bit of a word
    function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [OFF_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = OFF_W'(i);
            end
        end
        return idx;
    endfunction

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [WADDR_W-1:0]   cur_reg, cur_next;
    logic                 first_reg, first_next;
    rsp_t                 res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;
    logic [CNT_W-1:0]     bits_in_use_reg, bits_in_use_next;
    logic [RAM_DEPTH-1:0] valid_reg, valid_next;
    logic                 rd_valid_reg, rd_valid_next;

    logic                 ram_we;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic [CNT_W-1:0]     count;
    logic [WORD_W-1:0]    word_data;
    logic [OFF_W-1:0]     offset;
    logic [WORD_W-1:0]    bit_mask;
    logic [WORD_W-1:0]    new_word;
    logic [BYTE_W-1:0]    new_byte;
    logic [WORD_W-1:0]    match;
    logic [WORD_W-1:0]    start_mask;
    logic [WORD_W-1:0]    limit_mask;
    logic [WORD_W-1:0]    cand;
    logic [CNT_W-1:0]     next_base;
    logic                 out_free;

    abfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective bit count, saturated
    assign count = (bits_in_use_reg > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : bits_in_use_reg;

    // never-written words read as zero
    assign word_data = rd_valid_reg ? ram_rdata : '0;

    // single-bit update for a write
    assign offset   = req_reg.position[OFF_W-1:0];
    assign bit_mask = WORD_W'(1) << offset;
    assign new_word = req_reg.bit_value ? (word_data | bit_mask) : (word_data & ~bit_mask);
    assign new_byte = new_word[{offset[OFF_W-1:BIT_SEL_W], BIT_SEL_W'(0)} +: BYTE_W];
    assign ram_wdata = new_word;

    // find: matching bits, clipped to start position and bit count
    assign match      = req_reg.bit_value ? word_data : ~word_data;
    assign start_mask = first_reg ? ({WORD_W{1'b1}} << offset) : {WORD_W{1'b1}};
    assign limit_mask = ({1'b0, cur_reg} < count[CNT_W-1:OFF_W])
                      ? {WORD_W{1'b1}} : ~({WORD_W{1'b1}} << count[OFF_W-1:0]);
    assign cand       = match & start_mask & limit_mask;
    assign next_base  = {({1'b0, cur_reg} + (WADDR_W + 1)'(1)), OFF_W'(0)};

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign ram_raddr = (state_reg == S_IDLE) ? req_data.position[POS_W-1:OFF_W]
                                             : cur_reg + WADDR_W'(1);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        cur_next         = cur_reg;
        first_next       = first_reg;
        res_next         = res_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;
        bits_in_use_next = bits_in_use_reg;
        valid_next       = valid_reg;
        rd_valid_next    = valid_reg[ram_raddr];
        ram_we           = 1'b0;

        if (cfg_write)
        begin
            bits_in_use_next = cfg_data;
        end

        // response taken downstream
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data;
                    cur_next   = req_data.position[POS_W-1:OFF_W];
                    first_next = 1'b1;
                    res_next.status_code    = ST_OK;
                    res_next.found_position = req_data.position;
                    res_next.read_bit       = 1'b0;
                    res_next.entry_byte     = '0;
                    // the unused opcode never checks the range
                    if (req_data.opcode != OP_NONE && {1'b0, req_data.position} >= count)
                    begin
                        res_next.status_code = ST_RANGE;
                        state_next = S_RESP;
                    end
                    else if (req_data.opcode == OP_FIND)
                    begin
                        state_next = S_FIND;
                    end
                    else
                    begin
                        state_next = S_ACCESS;
                    end
                end
            end
            S_ACCESS:
            begin
                case (req_reg.opcode)
                    OP_READ:
                    begin
                        res_next.read_bit = word_data[offset];
                    end
                    OP_WRITE:
                    begin
                        res_next.entry_byte = new_byte;
                        ram_we              = 1'b1;
                        valid_next[cur_reg] = 1'b1;
                    end
                    default:
                    begin
                        res_next.read_bit = 1'b0;
                    end
                endcase
                state_next = S_RESP;
            end
            S_FIND:
            begin
                first_next = 1'b0;
                cur_next   = cur_reg + WADDR_W'(1);
                if (|cand)
                begin
                    res_next.found_position = {cur_reg, lowest_set(cand)};
                    state_next = S_RESP;
                end
                else if (next_base >= count)
                begin
                    res_next.status_code = ST_NOTFOUND;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            req_reg         <= '0;
            cur_reg         <= '0;
            first_reg       <= 1'b0;
            res_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
            bits_in_use_reg <= CNT_W'(MAX_BITS);
            valid_reg       <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            req_reg         <= req_next;
            cur_reg         <= cur_next;
            first_reg       <= first_next;
            res_reg         <= res_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_reg         <= rsp_next;
            bits_in_use_reg <= bits_in_use_next;
            valid_reg       <= valid_next;
            rd_valid_reg    <= rd_valid_next;
        end
    end

    // an accepted transaction always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg != S_IDLE)
        else $error("request accepted but unit stayed idle");

    // the scan advances exactly one word per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIND && $past(state_reg) == S_FIND
        |-> cur_reg == $past(cur_reg) + WADDR_W'(1))
        else $error("find scan did not advance by one word");

    // read bit and written byte never both reported
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.read_bit |-> rsp_reg.entry_byte == '0)
        else $error("read response carries a write byte");

endmodule
